[hw/rtl/imu_prr_pkg.sv]
// Package for the inertial sensor packet request/reply unit.
// Holds the protocol constants, operation codes, phase type and result entry type.
// No dependencies.
`timescale 1ns / 1ps

package imu_prr_pkg;

  // Input operation codes carried on the slave tuser
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RX_BYTE = 2'd1;
  localparam logic [1:0] OP_NO_BYTE = 2'd2;

  // Access kinds of a request
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;

  // Result kinds carried on the master tuser
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Final status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_ADDRESS  = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_P        = 3'd4;
  localparam logic [2:0] ST_N        = 3'd5;
  localparam logic [2:0] ST_S        = 3'd6;
  localparam logic [2:0] ST_NO_REPLY = 3'd7;

  // Packet header and flag constants
  localparam logic [7:0]  CHAR_S     = 8'h73;
  localparam logic [7:0]  CHAR_N     = 8'h6E;
  localparam logic [7:0]  CHAR_P     = 8'h70;
  localparam logic [8:0]  HDR_SUM    = 9'h151;
  localparam logic [7:0]  FLAG_DATA  = 8'h80;
  localparam logic [7:0]  FLAG_BATCH = 8'h40;
  localparam logic [3:0]  DEFAULT_DATA_BYTES = 4'd4;

  // Result buffer and reply store sizes
  localparam int RESULT_CAP  = 7;
  localparam int REPLY_DEPTH = 8;

  // Parser phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_S     = 10'b00_0000_0010,
    PH_N     = 10'b00_0000_0100,
    PH_P     = 10'b00_0000_1000,
    PH_TYPE  = 10'b00_0001_0000,
    PH_ADDR  = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_CKH   = 10'b00_1000_0000,
    PH_CKL   = 10'b01_0000_0000,
    PH_FLUSH = 10'b10_0000_0000
  } phase_t;

  // One result entry
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [2:0]  status;
  } result_t;

endpackage

[hw/rtl/imu_packet_request_reply_unit.sv]
// Packet request/reply unit for a serial inertial sensor link.
// Depends on imu_prr_pkg for constants, the phase type and the result entry type.
`timescale 1ns / 1ps

// Usage
// The slave stream takes one transaction per item: tuser carries the operation
// (request, received byte, no byte available) and tdata the request fields and
// the received byte. The master stream returns the results: tuser is the result
// kind (transmit byte, reply data word, final status), tlast marks the last
// result of the item that caused it.
// A request gives seven transmit bytes. Received bytes are parsed one per
// transaction; a completed reply gives the data words and then status ok, a
// failed check gives one status and the next FLUSH_COUNT byte items are
// discarded. The first result of an item is presented in the cycle after it is
// accepted. An item with k results takes k master transactions, so a request
// takes seven and a reply checksum item up to seven; items with no result, or
// one result while the receiver is ready, are taken every cycle. The seven-entry
// result buffer is the limit: a new item is accepted when it is empty or its
// last entry leaves. Reset clears the parser to idle and empties the result
// buffer. When the receiver stalls, the buffer holds and stops the slave side.

module imu_packet_request_reply_unit
  import imu_prr_pkg::*;
#(
  parameter int MAX_WORDS   = 4,
  parameter int FLUSH_COUNT = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] reg_address, [11:8] batch_bytes, [13:12] access_kind, [21:14] rx_byte
  input  logic [23:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_value, [18:16] status
  output logic [23:0] m_axis_tdata,
  // [1:0] out_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int NUM_WORDS = (MAX_WORDS < RESULT_CAP) ? MAX_WORDS : RESULT_CAP - 1;
  localparam int CNT_W     = $clog2(RESULT_CAP + 1);
  localparam logic [4:0] FLUSH_LOAD = 5'(FLUSH_COUNT);

  // Input fields
  logic [1:0] op;
  logic [7:0] reg_address;
  logic [3:0] batch_bytes;
  logic [1:0] access_kind;
  logic [7:0] rx_byte;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  want_address;
  logic [3:0]  want_batch;
  logic [1:0]  want_kind;
  logic [3:0]  byte_count, byte_count_next;
  logic [15:0] data_total, data_total_next;
  logic [7:0]  sum_high;
  logic [4:0]  discard_left, discard_left_next;
  logic [7:0]  reply_bytes [REPLY_DEPTH];

  // Result buffer
  result_t          bank [RESULT_CAP];
  result_t          res  [RESULT_CAP];
  logic [CNT_W-1:0] cnt, res_cnt;

  logic in_fire, out_fire, is_request, store_byte;

  // Derived request and reply values
  logic [7:0]  req_read_type, req_type;
  logic [15:0] req_ck;
  logic [7:0]  read_type, reply_type;
  logic [3:0]  need;
  logic [17:0] exp_sum;
  logic [15:0] got_sum;

  assign op          = s_axis_tuser;
  assign reg_address = s_axis_tdata[7:0];
  assign batch_bytes = s_axis_tdata[11:8];
  assign access_kind = s_axis_tdata[13:12];
  assign rx_byte     = s_axis_tdata[21:14];

  // Handshakes
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt == '0) || ((cnt == CNT_W'(1)) && m_axis_tready);
  assign is_request    = (op == OP_REQUEST);

  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tlast  = (cnt == CNT_W'(1));
  assign m_axis_tuser  = bank[0].kind;
  assign m_axis_tdata  = {5'd0, bank[0].status, bank[0].value};

  // Packet type of a new request, from the incoming fields
  assign req_read_type = ((batch_bytes != 4'd0) ? FLAG_BATCH : 8'd0) | {4'd0, batch_bytes};
  always_comb begin
    if (access_kind == ACC_READ) begin
      req_type = req_read_type;
    end else if (access_kind == ACC_WRITE) begin
      req_type = FLAG_DATA | req_read_type;
    end else begin
      req_type = 8'd0;
    end
  end
  assign req_ck = 16'(HDR_SUM) + 16'(req_type) + 16'(reg_address);

  // Expected reply values, from the stored request
  assign read_type  = ((want_batch != 4'd0) ? FLAG_BATCH : 8'd0) | {4'd0, want_batch};
  assign reply_type = (want_kind == ACC_READ) ? (FLAG_DATA | read_type) : 8'd0;
  assign need       = (want_batch != 4'd0) ? want_batch : DEFAULT_DATA_BYTES;
  assign exp_sum    = 18'(HDR_SUM) + 18'(reply_type) + 18'(want_address) + 18'(data_total);
  assign got_sum    = {sum_high, rx_byte};

  // Next parser state and the results of the current item
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    data_total_next   = data_total;
    discard_left_next = discard_left;
    store_byte        = 1'b0;
    res_cnt           = '0;
    for (int i = 0; i < RESULT_CAP; i++) begin
      res[i] = '0;
    end

    if (is_request) begin
      res[0].value = {8'd0, CHAR_S};
      res[1].value = {8'd0, CHAR_N};
      res[2].value = {8'd0, CHAR_P};
      res[3].value = {8'd0, req_type};
      res[4].value = {8'd0, reg_address};
      res[5].value = {8'd0, req_ck[15:8]};
      res[6].value = {8'd0, req_ck[7:0]};
      res_cnt           = CNT_W'(RESULT_CAP);
      byte_count_next   = '0;
      data_total_next   = '0;
      discard_left_next = '0;
      phase_next        = PH_S;
    end else if (op == OP_RX_BYTE || op == OP_NO_BYTE) begin
      if (phase == PH_FLUSH) begin
        // Discard one item; leave when the count runs out
        if (discard_left != 5'd0) begin
          discard_left_next = discard_left - 5'd1;
        end
        if (discard_left_next == 5'd0) begin
          phase_next = PH_IDLE;
        end
      end else if (phase != PH_IDLE && op == OP_NO_BYTE) begin
        // Sensor went quiet during a reply
        res[0].kind   = KIND_STATUS;
        res[0].status = ST_NO_REPLY;
        res_cnt       = CNT_W'(1);
        phase_next    = PH_IDLE;
      end else if (phase != PH_IDLE) begin
        // Default to an error result; cleared by the checks that pass
        res[0].kind       = KIND_STATUS;
        discard_left_next = FLUSH_LOAD;
        unique case (phase)
          PH_S: begin
            res[0].status = ST_S;
            res_cnt       = (rx_byte != CHAR_S) ? CNT_W'(1) : '0;
          end
          PH_N: begin
            res[0].status = ST_N;
            res_cnt       = (rx_byte != CHAR_N) ? CNT_W'(1) : '0;
          end
          PH_P: begin
            res[0].status = ST_P;
            res_cnt       = (rx_byte != CHAR_P) ? CNT_W'(1) : '0;
          end
          PH_TYPE: begin
            res[0].status = ST_TYPE;
            res_cnt       = (rx_byte != reply_type) ? CNT_W'(1) : '0;
          end
          PH_ADDR: begin
            res[0].status = ST_ADDRESS;
            res_cnt       = (rx_byte != want_address) ? CNT_W'(1) : '0;
            if (res_cnt == '0) begin
              byte_count_next = '0;
              data_total_next = '0;
              phase_next      = PH_DATA;
            end
          end
          PH_DATA: begin
            store_byte      = (byte_count < 4'(REPLY_DEPTH));
            data_total_next = data_total + 16'(rx_byte);
            byte_count_next = byte_count + 4'd1;
            if (byte_count_next >= need) begin
              phase_next = PH_CKH;
            end
          end
          PH_CKH: begin
            phase_next = PH_CKL;
          end
          PH_CKL: begin
            if ((want_kind == ACC_READ) ? (exp_sum == 18'(got_sum)) : (got_sum == 16'd0)) begin
              // Good reply: data words then status ok
              for (int i = 0; i < NUM_WORDS; i++) begin
                res[i].kind = KIND_WORD;
                if (2 * i + 1 < REPLY_DEPTH) begin
                  res[i].value = {reply_bytes[3'(2 * i)], reply_bytes[3'(2 * i + 1)]};
                end
              end
              res[NUM_WORDS].kind   = KIND_STATUS;
              res[NUM_WORDS].status = ST_OK;
              res_cnt               = CNT_W'(NUM_WORDS + 1);
              phase_next            = PH_IDLE;
            end else begin
              res[0].status = ST_CHECKSUM;
              res_cnt       = CNT_W'(1);
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
        // An error result sends the parser into the discard phase
        if (res_cnt == CNT_W'(1) && res[0].kind == KIND_STATUS) begin
          phase_next = (FLUSH_LOAD != 5'd0) ? PH_FLUSH : PH_IDLE;
        end else if (phase != PH_FLUSH) begin
          discard_left_next = discard_left;
          if (phase_next == PH_IDLE && res_cnt != '0) begin
            discard_left_next = discard_left;
          end
        end
        if (phase == PH_S || phase == PH_N || phase == PH_P || phase == PH_TYPE) begin
          if (res_cnt == '0) begin
            phase_next = phase_t'({phase[8:0], 1'b0});
          end
        end
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      want_address <= '0;
      want_batch   <= '0;
      want_kind    <= '0;
      byte_count   <= '0;
      data_total   <= '0;
      sum_high     <= '0;
      discard_left <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      data_total   <= data_total_next;
      discard_left <= discard_left_next;
      if (is_request) begin
        want_address <= reg_address;
        want_batch   <= batch_bytes;
        want_kind    <= access_kind;
        sum_high     <= '0;
      end else if (op == OP_RX_BYTE && phase == PH_CKH) begin
        sum_high <= rx_byte;
      end
    end
  end

  // Reply data store, cleared at each request
  always_ff @(posedge clk) begin
    if (in_fire && is_request) begin
      for (int i = 0; i < REPLY_DEPTH; i++) begin
        reply_bytes[i] <= '0;
      end
    end else if (in_fire && store_byte) begin
      reply_bytes[byte_count[2:0]] <= rx_byte;
    end
  end

  // Result buffer: loaded by an accepted item, shifted out one entry per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_fire) begin
      cnt <= res_cnt;
    end else if (out_fire) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < RESULT_CAP; i++) begin
        bank[i] <= res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < RESULT_CAP - 1; i++) begin
        bank[i] <= bank[i + 1];
      end
      bank[RESULT_CAP - 1] <= '0;
    end
  end

endmodule

[tb/tb_imu_packet_request_reply_unit.sv]
// Self-checking testbench for the inertial sensor packet request/reply unit.
// Drives request, byte and no-byte transactions and checks every result against
// its own model of the link. Depends on imu_prr_pkg and imu_packet_request_reply_unit.
`timescale 1ns / 1ps

module tb_imu_packet_request_reply_unit;
  import imu_prr_pkg::*;

  localparam int MAX_WORDS   = 4;
  localparam int DISCARDS    = 20;
  localparam int WORD_COUNT  = (MAX_WORDS < RESULT_CAP) ? MAX_WORDS : RESULT_CAP - 1;
  localparam int ITEM_TARGET = 470;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 20;

  // Codes that the package does not name
  localparam logic [1:0] OP_IGNORED  = 2'd3;
  localparam logic [1:0] ACC_COMMAND = 2'd2;
  localparam logic [1:0] ACC_SPARE   = 2'd3;

  // Entries of the stimulus feed: a transaction, or a control step for the driver
  typedef enum logic [1:0] {
    FEED_ITEM,
    FEED_MODE,
    FEED_HOLD,
    FEED_DRAIN
  } feed_t;

  typedef struct {
    feed_t      ctl;
    logic [1:0] op;
    logic [7:0] addr;
    logic [3:0] batch;
    logic [1:0] acc;
    logic [7:0] rx;
    int         mode;
  } link_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [2:0]  status;
    logic        last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  link_item_t   link_items[$];
  link_result_t pending_results[$];

  // Model state of the link
  phase_t      link_phase;
  logic [7:0]  req_addr;
  logic [3:0]  req_batch;
  logic [1:0]  req_kind;
  logic [3:0]  data_count;
  logic [15:0] reply_total;
  logic [7:0]  reply_store[REPLY_DEPTH];
  logic [7:0]  sum_hi;
  logic [4:0]  discards_left;

  int send_idle_pct = 24;
  int recv_idle_pct = 85;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_bad = 0;
  int stall_cycles = 0;
  int status_seen[8];

  link_item_t offered;
  link_item_t head;
  logic       go;

  imu_packet_request_reply_unit #(
    .MAX_WORDS   (MAX_WORDS),
    .FLUSH_COUNT (DISCARDS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  // Clock and the single reset at the start of the run.
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Packet type for a read of the given batch size.
  function automatic logic [7:0] batch_type(input logic [3:0] b);
    return (b > 0) ? (FLAG_BATCH | {4'h0, b}) : 8'h00;
  endfunction

  // Type byte that the sensor must answer with.
  function automatic logic [7:0] answer_type(input logic [1:0] acc, input logic [3:0] b);
    return (acc == ACC_READ) ? (FLAG_DATA | batch_type(b)) : 8'h00;
  endfunction

  task automatic expect_result(input logic [1:0] kind, input logic [15:0] value,
                               input logic [2:0] status, input logic last);
    link_result_t r;
    r.kind = kind;
    r.value = value;
    r.status = status;
    r.last = last;
    pending_results.push_back(r);
  endtask

  // An error status; the following byte transactions are then thrown away.
  task automatic reject_reply(input logic [2:0] code);
    discards_left = 5'(DISCARDS);
    link_phase = (discards_left > 0) ? PH_FLUSH : PH_IDLE;
    expect_result(KIND_STATUS, 16'h0000, code, 1'b1);
  endtask

  // Works out the results of one accepted transaction and updates the model state.
  task automatic predict_link_results(input link_item_t it);
    logic [7:0]  pt;
    logic [15:0] ck;
    logic [15:0] got;
    logic [31:0] want;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        ok;
    int          need;
    if (it.op == OP_REQUEST) begin
      req_addr = it.addr;
      req_batch = it.batch;
      req_kind = it.acc;
      if (req_kind == ACC_READ) pt = batch_type(req_batch);
      else if (req_kind == ACC_WRITE) pt = FLAG_DATA | batch_type(req_batch);
      else pt = 8'h00;
      ck = HDR_SUM + pt + req_addr;
      expect_result(KIND_TX, {8'h00, CHAR_S}, ST_OK, 1'b0);
      expect_result(KIND_TX, {8'h00, CHAR_N}, ST_OK, 1'b0);
      expect_result(KIND_TX, {8'h00, CHAR_P}, ST_OK, 1'b0);
      expect_result(KIND_TX, {8'h00, pt}, ST_OK, 1'b0);
      expect_result(KIND_TX, {8'h00, req_addr}, ST_OK, 1'b0);
      expect_result(KIND_TX, {8'h00, ck[15:8]}, ST_OK, 1'b0);
      expect_result(KIND_TX, {8'h00, ck[7:0]}, ST_OK, 1'b1);
      foreach (reply_store[i]) reply_store[i] = 8'h00;
      data_count = '0;
      reply_total = '0;
      sum_hi = '0;
      discards_left = '0;
      link_phase = PH_S;
      return;
    end
    if (it.op == OP_IGNORED || link_phase == PH_IDLE) return;
    if (link_phase == PH_FLUSH) begin
      if (discards_left > 0) discards_left = discards_left - 1;
      if (discards_left == 0) link_phase = PH_IDLE;
      return;
    end
    // A missing byte ends the wait at any point of the reply, with no flush.
    if (it.op == OP_NO_BYTE) begin
      link_phase = PH_IDLE;
      expect_result(KIND_STATUS, 16'h0000, ST_NO_REPLY, 1'b1);
      return;
    end
    case (link_phase)
      PH_S: begin
        if (it.rx != CHAR_S) reject_reply(ST_S);
        else link_phase = PH_N;
      end
      PH_N: begin
        if (it.rx != CHAR_N) reject_reply(ST_N);
        else link_phase = PH_P;
      end
      PH_P: begin
        if (it.rx != CHAR_P) reject_reply(ST_P);
        else link_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (it.rx != answer_type(req_kind, req_batch)) reject_reply(ST_TYPE);
        else link_phase = PH_ADDR;
      end
      PH_ADDR: begin
        if (it.rx != req_addr) begin
          reject_reply(ST_ADDRESS);
        end else begin
          data_count = '0;
          reply_total = '0;
          link_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        // Every data byte is summed, but only the first eight are kept.
        need = (req_batch > 0) ? int'(req_batch) : int'(DEFAULT_DATA_BYTES);
        if (data_count < REPLY_DEPTH) reply_store[data_count[2:0]] = it.rx;
        reply_total = reply_total + it.rx;
        data_count = data_count + 1;
        if (data_count >= need) link_phase = PH_CKH;
      end
      PH_CKH: begin
        sum_hi = it.rx;
        link_phase = PH_CKL;
      end
      PH_CKL: begin
        got = {sum_hi, it.rx};
        if (req_kind == ACC_READ) begin
          want = HDR_SUM + answer_type(req_kind, req_batch) + req_addr + reply_total;
          ok = ({16'h0000, got} == want);
        end else begin
          ok = (got == 16'h0000);
        end
        if (!ok) begin
          reject_reply(ST_CHECKSUM);
        end else begin
          for (int i = 0; i < WORD_COUNT; i++) begin
            hi = (2 * i < REPLY_DEPTH) ? reply_store[2 * i] : 8'h00;
            lo = (2 * i + 1 < REPLY_DEPTH) ? reply_store[2 * i + 1] : 8'h00;
            expect_result(KIND_WORD, {hi, lo}, ST_OK, 1'b0);
          end
          link_phase = PH_IDLE;
          expect_result(KIND_STATUS, 16'h0000, ST_OK, 1'b1);
        end
      end
      default: link_phase = PH_IDLE;
    endcase
  endtask

  // Queues one transaction; fields that the operation does not use are random.
  task automatic push_item(input logic [1:0] op, input logic [7:0] addr,
                           input logic [3:0] batch, input logic [1:0] acc,
                           input logic [7:0] rx);
    link_item_t it;
    it.ctl = FEED_ITEM;
    it.op = op;
    it.addr = (op == OP_REQUEST) ? addr : 8'($urandom);
    it.batch = (op == OP_REQUEST) ? batch : 4'($urandom);
    it.acc = (op == OP_REQUEST) ? acc : 2'($urandom);
    it.rx = (op == OP_RX_BYTE) ? rx : 8'($urandom);
    it.mode = 0;
    link_items.push_back(it);
    if (op != OP_IGNORED) n_queued++;
  endtask

  task automatic push_control(input feed_t ctl, input int mode);
    link_item_t it;
    it.ctl = ctl;
    it.op = OP_IGNORED;
    it.addr = '0;
    it.batch = '0;
    it.acc = '0;
    it.rx = '0;
    it.mode = mode;
    link_items.push_back(it);
  endtask

  // Transaction with no meaning in the current state: byte, no byte or op 3.
  task automatic push_noise();
    case ($urandom_range(2))
      0: push_item(OP_RX_BYTE, 8'h00, 4'h0, 2'd0, 8'($urandom));
      1: push_item(OP_NO_BYTE, 8'h00, 4'h0, 2'd0, 8'h00);
      default: push_item(OP_IGNORED, 8'h00, 4'h0, 2'd0, 8'h00);
    endcase
  endtask

  // A request followed by the sensor's reply. One byte may be spoiled, the reply
  // may stop early (with or without a no-byte transaction), and after an error a
  // tail of further bytes runs through the discard window.
  task automatic add_exchange(input logic [7:0] addr, input logic [3:0] batch,
                              input logic [1:0] acc, input int spoil_at,
                              input int cut_at, input logic no_byte, input int tail);
    logic [7:0]  reply[$];
    logic [7:0]  b;
    logic [15:0] ck;
    int          need;
    int          stop;
    push_item(OP_REQUEST, addr, batch, acc, 8'h00);
    reply = {CHAR_S, CHAR_N, CHAR_P, answer_type(acc, batch), addr};
    need = (batch > 0) ? int'(batch) : int'(DEFAULT_DATA_BYTES);
    ck = HDR_SUM + answer_type(acc, batch) + addr;
    for (int i = 0; i < need; i++) begin
      b = 8'($urandom);
      reply.push_back(b);
      ck = ck + b;
    end
    if (acc != ACC_READ) ck = 16'h0000;
    reply.push_back(ck[15:8]);
    reply.push_back(ck[7:0]);
    if (spoil_at >= 0) reply[spoil_at] = reply[spoil_at] ^ 8'($urandom_range(255, 1));
    stop = (cut_at >= 0) ? cut_at : reply.size();
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(19) == 0) push_item(OP_IGNORED, 8'h00, 4'h0, 2'd0, 8'h00);
      push_item(OP_RX_BYTE, 8'h00, 4'h0, 2'd0, reply[i]);
    end
    if (no_byte) push_item(OP_NO_BYTE, 8'h00, 4'h0, 2'd0, 8'h00);
    repeat (tail) begin
      if ($urandom_range(4) == 0) push_item(OP_NO_BYTE, 8'h00, 4'h0, 2'd0, 8'h00);
      else if ($urandom_range(9) == 0) push_item(OP_IGNORED, 8'h00, 4'h0, 2'd0, 8'h00);
      else push_item(OP_RX_BYTE, 8'h00, 4'h0, 2'd0, 8'($urandom));
    end
  endtask

  // Random exchange: mostly clean replies with random data, the rest faulty.
  task automatic add_random_exchange();
    logic [7:0] addr;
    logic [3:0] batch;
    logic [1:0] acc;
    int         pick;
    int         fault;
    int         len;
    addr = 8'($urandom);
    batch = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    pick = $urandom_range(99);
    if (pick < 40) acc = ACC_READ;
    else if (pick < 65) acc = ACC_WRITE;
    else if (pick < 90) acc = ACC_COMMAND;
    else acc = ACC_SPARE;
    len = 7 + ((batch > 0) ? int'(batch) : int'(DEFAULT_DATA_BYTES));
    fault = $urandom_range(99);
    if (fault < 25)
      add_exchange(addr, batch, acc, $urandom_range(len - 1), -1, 1'b0, $urandom_range(24));
    else if (fault < 35)
      add_exchange(addr, batch, acc, -1, $urandom_range(len - 1), 1'b1, 0);
    else if (fault < 40)
      add_exchange(addr, batch, acc, -1, $urandom_range(len - 1), 1'b0, 0);
    else
      add_exchange(addr, batch, acc, -1, -1, 1'b0, 0);
    if ($urandom_range(19) == 0) repeat ($urandom_range(3, 1)) push_noise();
  endtask

  // Driver: offers the next queued transaction and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_link_results(offered);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        go = 1'b0;
        while (link_items.size() > 0 &&
               (link_items[0].ctl == FEED_MODE || link_items[0].ctl == FEED_HOLD)) begin
          head = link_items.pop_front();
          if (head.ctl == FEED_HOLD) begin
            holds_asked++;
          end else begin
            case (head.mode)
              0: begin
                send_idle_pct = 24;
                recv_idle_pct = 85;
              end
              1: begin
                send_idle_pct = 85;
                recv_idle_pct = 24;
              end
              default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
              end
            endcase
          end
        end
        if (link_items.size() > 0) begin
          if (link_items[0].ctl == FEED_DRAIN) begin
            // Pause until every outstanding result has been taken.
            if (pending_results.size() == 0 && !(s_tvalid && s_tready))
              void'(link_items.pop_front());
          end else if ($urandom_range(99) >= send_idle_pct) begin
            offered = link_items.pop_front();
            s_tdata <= {2'b00, offered.rx, offered.acc, offered.batch, offered.addr};
            s_tuser <= offered.op;
            go = 1'b1;
          end
        end
        s_tvalid <= go;
      end
    end
  end

  // Receiver: random back-pressure, plus long hold-offs when the driver asks.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    link_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%04h status %0d last %0b",
               m_tuser, m_tdata[15:0], m_tdata[18:16], m_tlast);
        n_bad++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.kind == KIND_STATUS) status_seen[exp_r.status]++;
        if (m_tuser !== exp_r.kind) begin
          $error("out_kind: expected %0d, got %0d", exp_r.kind, m_tuser);
          n_bad++;
        end
        if (m_tdata[15:0] !== exp_r.value) begin
          $error("out_value: expected 0x%04h, got 0x%04h", exp_r.value, m_tdata[15:0]);
          n_bad++;
        end
        if (m_tdata[18:16] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tdata[18:16]);
          n_bad++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, m_tlast);
          n_bad++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timed out with %0d results still outstanding", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic mid_done;
    logic late_done;
    mid_done = 1'b0;
    late_done = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // The model starts from the state that reset leaves the block in.
    link_phase = PH_IDLE;
    req_addr = '0;
    req_batch = '0;
    req_kind = '0;
    data_count = '0;
    reply_total = '0;
    foreach (reply_store[i]) reply_store[i] = 8'h00;
    sum_hi = '0;
    discards_left = '0;

    // Directed part: idle noise, spare access kind, request while busy, a clean
    // read, a reply cut short by a missing byte and a header error with flush.
    push_control(FEED_MODE, 0);
    push_item(OP_IGNORED, 8'h00, 4'h0, 2'd0, 8'h00);
    push_item(OP_RX_BYTE, 8'h00, 4'h0, 2'd0, 8'hFF);
    push_item(OP_NO_BYTE, 8'h00, 4'h0, 2'd0, 8'h00);
    push_item(OP_REQUEST, 8'h00, 4'hF, ACC_SPARE, 8'h00);
    add_exchange(8'hFF, 4'h0, ACC_READ, -1, -1, 1'b0, 0);
    add_exchange(8'h5A, 4'h2, ACC_WRITE, -1, 1, 1'b1, 0);
    add_exchange(8'h33, 4'h1, ACC_READ, 0, 1, 1'b0, 2);
    push_control(FEED_DRAIN, 0);

    // Random part in three idling phases; the last one starts with a long hold-off.
    while (n_queued < ITEM_TARGET) begin
      if (!mid_done && n_queued >= ITEM_TARGET / 3) begin
        push_control(FEED_DRAIN, 0);
        push_control(FEED_MODE, 1);
        mid_done = 1'b1;
      end
      if (!late_done && n_queued >= 2 * ITEM_TARGET / 3) begin
        push_control(FEED_DRAIN, 0);
        push_control(FEED_MODE, 2);
        push_control(FEED_HOLD, 0);
        late_done = 1'b1;
      end
      add_random_exchange();
    end

    @(negedge rst);
    while (link_items.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d transactions in and %0d results out; %0d replies passed,",
             n_accepted, n_results, status_seen[ST_OK]);
    $display("%0d rejected by header, type, address or checksum, %0d ended by no byte.",
             status_seen[ST_CHECKSUM] + status_seen[ST_ADDRESS] + status_seen[ST_TYPE] +
             status_seen[ST_P] + status_seen[ST_N] + status_seen[ST_S],
             status_seen[ST_NO_REPLY]);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
